@@ rtl/rdi_pkg.sv @@
// ---------------------------------------------------------------------------
// rdi_pkg: shared types for the ray / disk intersection pipeline
// Word layouts, configuration register codes and inter-stage payloads.
// ---------------------------------------------------------------------------
package rdi_pkg;

  // magnitude widths inside the datapath
  localparam int unsigned DEN_W = 50;  // |normal . dir|
  localparam int unsigned NUM_W = 51;  // |normal . (center - start)|
  localparam int unsigned T_W   = 31;  // Q15.16 ray parameter, non-negative
  localparam int unsigned LO_W  = 15;  // numerator bits still to shift in
  localparam int unsigned IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    IDX_CENTER_X = 3'd0,
    IDX_CENTER_Y = 3'd1,
    IDX_CENTER_Z = 3'd2,
    IDX_NORMAL_X = 3'd3,
    IDX_NORMAL_Y = 3'd4,
    IDX_NORMAL_Z = 3'd5,
    IDX_RADIUS   = 3'd6
  } cfg_idx_e;

  // input word: one ray
  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

  // output word: hit flag and hit point
  typedef struct packed {
    logic               hit;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } res_t;

  // disk description
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [17:0] normal_x;
    logic signed [17:0] normal_y;
    logic signed [17:0] normal_z;
    logic [30:0]        disk_radius;
  } cfg_t;

  // divider payload, one per divider stage
  typedef struct packed {
    ray_t             ray;
    logic             miss;
    logic             sat;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [LO_W-1:0]  num_lo;
    logic [T_W-1:0]   quo;
  } div_t;

endpackage

@@ rtl/rdi_front.sv @@
// ---------------------------------------------------------------------------
// rdi_front: dot products and divider setup
// Three stages: lane products, sums and sign check, saturation test.
// ---------------------------------------------------------------------------
module rdi_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rdi_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  rdi_pkg::ray_t ray_i,
  output logic          valid_o,
  input  logic          ready_i,
  output rdi_pkg::div_t div_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  // ready ripples back; an empty stage always loads
  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // stage 1: per-lane products
  logic signed [31:0] s_a [3];
  logic signed [31:0] d_a [3];
  logic signed [31:0] c_a [3];
  logic signed [17:0] n_a [3];
  logic signed [49:0] pd_d [3];
  logic signed [50:0] pn_d [3];
  logic signed [49:0] pd_q [3];
  logic signed [50:0] pn_q [3];
  rdi_pkg::ray_t      ray1_q;

  assign s_a[0] = ray_i.start_x;
  assign s_a[1] = ray_i.start_y;
  assign s_a[2] = ray_i.start_z;
  assign d_a[0] = ray_i.dir_x;
  assign d_a[1] = ray_i.dir_y;
  assign d_a[2] = ray_i.dir_z;
  assign c_a[0] = cfg_i.center_x;
  assign c_a[1] = cfg_i.center_y;
  assign c_a[2] = cfg_i.center_z;
  assign n_a[0] = cfg_i.normal_x;
  assign n_a[1] = cfg_i.normal_y;
  assign n_a[2] = cfg_i.normal_z;

  always_comb begin
    logic signed [32:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff    = 33'(c_a[i]) - 33'(s_a[i]);
      pd_d[i] = 50'(n_a[i]) * 50'(d_a[i]);
      pn_d[i] = 51'(n_a[i]) * 51'(diff);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      ray1_q <= ray_i;
      for (int i = 0; i < 3; i++) begin
        pd_q[i] <= pd_d[i];
        pn_q[i] <= pn_d[i];
      end
    end
  end

  // stage 2: sums, parallel / behind check, magnitudes
  logic signed [50:0]           dot_d;
  logic signed [51:0]           num_d;
  logic                         miss2_d;
  logic [rdi_pkg::NUM_W-1:0]    a2_d;
  logic [rdi_pkg::DEN_W-1:0]    b2_d;
  logic                         miss2_q;
  logic [rdi_pkg::NUM_W-1:0]    a2_q;
  logic [rdi_pkg::DEN_W-1:0]    b2_q;
  rdi_pkg::ray_t                ray2_q;

  always_comb begin
    logic signed [50:0] ndot;
    logic signed [51:0] nnum;
    dot_d   = 51'(pd_q[0]) + 51'(pd_q[1]) + 51'(pd_q[2]);
    num_d   = 52'(pn_q[0]) + 52'(pn_q[1]) + 52'(pn_q[2]);
    ndot    = -dot_d;
    nnum    = -num_d;
    miss2_d = (dot_d == '0) || ((num_d != '0) && (num_d[51] != dot_d[50]));
    a2_d    = num_d[51] ? nnum[rdi_pkg::NUM_W-1:0] : num_d[rdi_pkg::NUM_W-1:0];
    b2_d    = dot_d[50] ? ndot[rdi_pkg::DEN_W-1:0] : dot_d[rdi_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      ray2_q  <= ray1_q;
      miss2_q <= miss2_d;
      a2_q    <= a2_d;
      b2_q    <= b2_d;
    end
  end

  // stage 3: quotient overflow test and first partial remainder
  rdi_pkg::div_t div_d, div_q;

  always_comb begin
    div_d        = '0;
    div_d.ray    = ray2_q;
    div_d.miss   = miss2_q;
    div_d.sat    = {15'd0, a2_q} >= {1'b0, b2_q, 15'd0};
    div_d.den    = b2_q;
    div_d.rem    = rdi_pkg::DEN_W'(a2_q >> rdi_pkg::LO_W);
    div_d.num_lo = a2_q[rdi_pkg::LO_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      div_q <= div_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign div_o   = div_q;

endmodule

@@ rtl/rdi_div.sv @@
// ---------------------------------------------------------------------------
// rdi_div: pipelined restoring divider
// One quotient bit per stage, t = |num| * 2^16 / |dot|, 31 stages.
// ---------------------------------------------------------------------------
module rdi_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  rdi_pkg::div_t div_i,
  output logic          valid_o,
  input  logic          ready_i,
  output rdi_pkg::div_t div_o
);

  localparam int unsigned NSTG = rdi_pkg::T_W;

  rdi_pkg::div_t stg_q [NSTG];
  logic          vld_q [NSTG];
  logic          rdy   [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    localparam int J = NSTG - 1 - k;  // quotient bit made here

    rdi_pkg::div_t           src;
    rdi_pkg::div_t           nxt;
    logic                    src_v;
    logic                    down_rdy;
    logic                    nbit;
    logic [rdi_pkg::DEN_W:0] rs;
    logic [rdi_pkg::DEN_W:0] df;
    logic                    ge;

    if (k == 0) begin : g_head
      assign src   = div_i;
      assign src_v = valid_i;
    end else begin : g_body
      assign src   = stg_q[k-1];
      assign src_v = vld_q[k-1];
    end

    if (k == NSTG - 1) begin : g_tail
      assign down_rdy = ready_i;
    end else begin : g_mid
      assign down_rdy = rdy[k+1];
    end

    // next dividend bit: numerator bits above bit 15, zeros below
    if (J >= 16) begin : g_bit
      assign nbit = src.num_lo[J-16];
    end else begin : g_zero
      assign nbit = 1'b0;
    end

    // compare and subtract
    always_comb begin
      rs      = {src.rem, nbit};
      df      = rs - {1'b0, src.den};
      ge      = rs >= {1'b0, src.den};
      nxt     = src;
      nxt.rem = ge ? df[rdi_pkg::DEN_W-1:0] : rs[rdi_pkg::DEN_W-1:0];
      nxt.quo = {src.quo[rdi_pkg::T_W-2:0], ge};
    end

    assign rdy[k] = !vld_q[k] || down_rdy;

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        stg_q[k] <= nxt;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= src_v;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[NSTG-1];
  assign div_o   = stg_q[NSTG-1];

endmodule

@@ rtl/rdi_back.sv @@
// ---------------------------------------------------------------------------
// rdi_back: hit point and disk test
// Four stages: dir * t, point and distance, squares, sum and compare.
// ---------------------------------------------------------------------------
module rdi_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rdi_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  rdi_pkg::div_t div_i,
  output logic          valid_o,
  input  logic          ready_i,
  output rdi_pkg::res_t res_o
);

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -49'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4    = !v4_q || ready_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  logic signed [31:0] c_a [3];
  assign c_a[0] = cfg_i.center_x;
  assign c_a[1] = cfg_i.center_y;
  assign c_a[2] = cfg_i.center_z;

  // stage 1: dir * t, t saturated
  logic [rdi_pkg::T_W-1:0] t;
  logic signed [31:0]      s_a [3];
  logic signed [31:0]      d_a [3];
  logic signed [63:0]      prod_q [3];
  logic signed [31:0]      s1_q [3];
  logic                    miss1_q;

  assign t      = div_i.sat ? {rdi_pkg::T_W{1'b1}} : div_i.quo;
  assign s_a[0] = div_i.ray.start_x;
  assign s_a[1] = div_i.ray.start_y;
  assign s_a[2] = div_i.ray.start_z;
  assign d_a[0] = div_i.ray.dir_x;
  assign d_a[1] = div_i.ray.dir_y;
  assign d_a[2] = div_i.ray.dir_z;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      miss1_q <= div_i.miss;
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= 64'(d_a[i]) * 64'($signed({1'b0, t}));
        s1_q[i]   <= s_a[i];
      end
    end
  end

  // stage 2: wide point, distance magnitude, out-of-radius flag
  logic signed [48:0] p_d  [3];
  logic [30:0]        am_d [3];
  logic               far_d;
  logic signed [48:0] p2_q [3];
  logic [30:0]        am2_q [3];
  logic               far2_q;
  logic               miss2_q;

  always_comb begin
    logic signed [63:0] shf;
    logic signed [49:0] diff;
    logic [49:0]        amag;
    far_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      shf     = prod_q[i] >>> 16;
      p_d[i]  = 49'(s1_q[i]) + shf[48:0];
      diff    = 50'(p_d[i]) - 50'(c_a[i]);
      amag    = diff[49] ? 50'(-diff) : 50'(diff);
      am_d[i] = amag[30:0];
      if (amag >= {19'd0, cfg_i.disk_radius}) far_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      miss2_q <= miss1_q;
      far2_q  <= far_d;
      for (int i = 0; i < 3; i++) begin
        p2_q[i]  <= p_d[i];
        am2_q[i] <= am_d[i];
      end
    end
  end

  // stage 3: squares
  logic [61:0]        sq3_q [3];
  logic [61:0]        rad2_q;
  logic signed [48:0] p3_q [3];
  logic               far3_q;
  logic               miss3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      miss3_q <= miss2_q;
      far3_q  <= far2_q;
      rad2_q  <= 62'(cfg_i.disk_radius) * 62'(cfg_i.disk_radius);
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= 62'(am2_q[i]) * 62'(am2_q[i]);
        p3_q[i]  <= p2_q[i];
      end
    end
  end

  // stage 4: distance sum, verdict, output word
  logic [63:0]   dsum;
  logic          hit_d;
  rdi_pkg::res_t res_d, res_q;

  always_comb begin
    dsum          = 64'(sq3_q[0]) + 64'(sq3_q[1]) + 64'(sq3_q[2]);
    hit_d         = !miss3_q && !far3_q && (dsum < 64'(rad2_q));
    res_d         = '0;
    res_d.hit     = hit_d;
    if (hit_d) begin
      res_d.point_x = sat32(p3_q[0]);
      res_d.point_y = sat32(p3_q[1]);
      res_d.point_z = sat32(p3_q[2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  assign valid_o = v4_q;
  assign res_o   = res_q;

endmodule

@@ rtl/ray_disk_intersect_top.sv @@
// ---------------------------------------------------------------------------
// ray_disk_intersect_top: ray / disk intersection pipeline
// Tests each ray against a configured disk and returns hit and hit point.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+------------------
//  in       | input     | in_valid_i / in_stall_o    | rdi_pkg::ray_t
//  out      | output    | out_valid_o / out_stall_i  | rdi_pkg::res_t
//  cfg      | input     | cfg_we_i, cfg_idx_i        | cfg_data_i
//
//  One ray per cycle sustained while out_stall_i stays low; the rays pass
//  through setup, divider and back stages, one quotient bit per divider stage.
//  Reset clears all valid bits and loads the default unit disk on the z axis.
//  A stall backs up stage by stage; empty stages keep loading, so bubbles
//  close up and no word is lost or repeated.
// ---------------------------------------------------------------------------
module ray_disk_intersect_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rdi_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rdi_pkg::ray_t               in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rdi_pkg::res_t               out_word_o
);

  // configuration registers
  rdi_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q             <= '0;
      cfg_q.normal_z    <= 18'sd65536;
      cfg_q.disk_radius <= 31'd65536;
    end else if (cfg_we_i) begin
      case (rdi_pkg::cfg_idx_e'(cfg_idx_i))
        rdi_pkg::IDX_CENTER_X: cfg_q.center_x    <= cfg_data_i;
        rdi_pkg::IDX_CENTER_Y: cfg_q.center_y    <= cfg_data_i;
        rdi_pkg::IDX_CENTER_Z: cfg_q.center_z    <= cfg_data_i;
        rdi_pkg::IDX_NORMAL_X: cfg_q.normal_x    <= cfg_data_i[17:0];
        rdi_pkg::IDX_NORMAL_Y: cfg_q.normal_y    <= cfg_data_i[17:0];
        rdi_pkg::IDX_NORMAL_Z: cfg_q.normal_z    <= cfg_data_i[17:0];
        rdi_pkg::IDX_RADIUS:   cfg_q.disk_radius <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // pipeline
  logic          in_rdy;
  logic          f_vld, f_rdy;
  rdi_pkg::div_t f_div;
  logic          d_vld, d_rdy;
  rdi_pkg::div_t d_div;

  rdi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (in_rdy),
    .ray_i   (in_word_i),
    .valid_o (f_vld),
    .ready_i (f_rdy),
    .div_o   (f_div)
  );

  rdi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld),
    .ready_o (f_rdy),
    .div_i   (f_div),
    .valid_o (d_vld),
    .ready_i (d_rdy),
    .div_o   (d_div)
  );

  rdi_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (d_vld),
    .ready_o (d_rdy),
    .div_i   (d_div),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .res_o   (out_word_o)
  );

  assign in_stall_o = !in_rdy;

`ifndef SYNTHESIS
  // a miss reports a zero point
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.hit) |->
      (out_word_o.point_x == '0 && out_word_o.point_y == '0 &&
       out_word_o.point_z == '0))
    else $error("miss word carries a nonzero point");

  // input can only back up when the output register is full
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // a zero radius never gives a hit
  a_zero_rad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.hit) |-> (cfg_q.disk_radius != '0))
    else $error("hit reported for zero radius");
`endif

endmodule
